// File: hdl/mbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants of the MIDI byte stream parser.
// ----------------------------------------------------------------------------
package mbp_pkg;

  typedef enum logic [2:0] {
    KIND_NOTHING  = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_NOTE_OFF = 3'd2,
    KIND_PITCH    = 3'd3,
    KIND_CC       = 3'd4,
    KIND_PROG     = 3'd5,
    KIND_SYSEX    = 3'd6
  } mbp_kind_e;

  // upper nibble of status bytes
  localparam logic [3:0] HI_NOTE_OFF = 4'h8;
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [3:0] HI_CC       = 4'hB;
  localparam logic [3:0] HI_PROG     = 4'hC;
  localparam logic [3:0] HI_PITCH    = 4'hE;
  localparam logic [3:0] HI_SYSTEM   = 4'hF;

  // lower nibble of system status bytes
  localparam logic [3:0] LO_SYSEX_START = 4'h0;
  localparam logic [3:0] LO_SYSEX_END   = 4'h7;

  // parser state seen by the emitter
  typedef struct packed {
    mbp_kind_e   kind;
    logic [3:0]  chan;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [4:0]  sysex_count;
  } mbp_state_t;

  // event request raised with an accepted item
  typedef struct packed {
    logic single;  // one result straight from the next state
    logic multi;   // sysex with stored bytes, walk the store
  } mbp_ev_t;

  // one result item
  typedef struct packed {
    mbp_kind_e   kind;
    logic [3:0]  chan;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [4:0]  sysex_count;
    logic [3:0]  payload_index;
    logic [6:0]  payload_value;
    logic        last_of_event;
  } mbp_res_t;

endpackage
`default_nettype wire

// File: hdl/mbp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_parser
// Parse state, next-state logic and the data byte store.
// ----------------------------------------------------------------------------
module mbp_parser #(
  parameter int SYSEX_MAX = 16,
  localparam int IDXW = (SYSEX_MAX > 1) ? $clog2(SYSEX_MAX) : 1,
  localparam int FW   = $clog2(SYSEX_MAX + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         rx_byte_i,
  output mbp_pkg::mbp_state_t     cur_o,
  output mbp_pkg::mbp_state_t     nxt_o,
  output mbp_pkg::mbp_ev_t        ev_o,
  output logic [FW-1:0]           fill_o,
  input  wire logic               rd_en_i,
  input  wire logic [IDXW-1:0]    rd_addr_i,
  output logic [6:0]              rd_data_o
);
  import mbp_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_WAIT1 = 3'd1;
  localparam logic [2:0] PH_WAIT2 = 3'd2;
  localparam logic [2:0] PH_SYSEX = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [FW-1:0] FILL_MAX = FW'(SYSEX_MAX);

  logic [2:0]      phase_q, phase_d;
  mbp_kind_e       kind_q, kind_d;
  logic [3:0]      chan_q, chan_d;
  logic [6:0]      d0_q, d0_d;
  logic [6:0]      d1_q, d1_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic            wr_en;
  logic [IDXW-1:0] wr_addr;
  logic [6:0]      mem_q [SYSEX_MAX];
  logic [6:0]      rd_q;
  logic [3:0]      hi, lo;
  logic [6:0]      data;
  logic [31:0]     fill_q_ext, fill_d_ext;

  assign hi   = rx_byte_i[7:4];
  assign lo   = rx_byte_i[3:0];
  assign data = rx_byte_i[6:0];

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    chan_d  = chan_q;
    fill_d  = fill_q;
    wr_en   = 1'b0;
    wr_addr = '0;
    if (rx_byte_i[7]) begin
      if (hi == HI_SYSTEM) begin
        if (lo == LO_SYSEX_START) begin
          kind_d  = KIND_SYSEX;
          fill_d  = '0;
          phase_d = PH_SYSEX;
        end else if (lo == LO_SYSEX_END) begin
          phase_d = PH_DONE;
        end
      end else begin
        case (hi)
          HI_NOTE_ON:  kind_d = KIND_NOTE_ON;
          HI_NOTE_OFF: kind_d = KIND_NOTE_OFF;
          HI_PITCH:    kind_d = KIND_PITCH;
          HI_CC:       kind_d = KIND_CC;
          HI_PROG:     kind_d = KIND_PROG;
          default:     kind_d = KIND_NOTHING;
        endcase
        if (kind_d == KIND_NOTHING) begin
          phase_d = PH_IDLE;
        end else begin
          phase_d = PH_WAIT1;
          chan_d  = lo;
        end
      end
    end else begin
      case (phase_q)
        PH_WAIT1: begin
          wr_en = 1'b1;
          if (kind_q inside {KIND_NOTE_ON, KIND_NOTE_OFF, KIND_PITCH, KIND_CC}) begin
            phase_d = PH_WAIT2;
          end else if (kind_q == KIND_PROG) begin
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_WAIT2: begin
          wr_en   = 1'b1;
          wr_addr = IDXW'(1);
          phase_d = PH_DONE;
        end
        PH_SYSEX: begin
          if (fill_q < FILL_MAX) begin
            wr_en   = 1'b1;
            wr_addr = fill_q[IDXW-1:0];
            fill_d  = fill_q + FW'(1);
          end
          if (fill_d >= FILL_MAX) begin
            phase_d = PH_DONE;
          end
        end
        PH_DONE: begin
          // running status: data byte opens a new message
          wr_en   = 1'b1;
          phase_d = PH_WAIT2;
        end
        default: ;
      endcase
    end
  end

  // mirrors of entries zero and one for the fixed fields
  always_comb begin
    d0_d = d0_q;
    d1_d = d1_q;
    if (wr_en && wr_addr == IDXW'(0)) d0_d = data;
    if (wr_en && wr_addr == IDXW'(1)) d1_d = data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      kind_q  <= KIND_NOTHING;
      chan_q  <= '0;
      d0_q    <= '0;
      d1_q    <= '0;
      fill_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      chan_q  <= chan_d;
      d0_q    <= d0_d;
      d1_q    <= d1_d;
      fill_q  <= fill_d;
    end
  end

  // only entries written since the last sysex start are ever read
  always_ff @(posedge clk_i) begin
    if (accept_i && wr_en) begin
      mem_q[wr_addr] <= data;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign fill_q_ext = 32'(fill_q);
  assign fill_d_ext = 32'(fill_d);

  always_comb begin
    cur_o.kind        = kind_q;
    cur_o.chan        = chan_q;
    cur_o.first_data  = d0_q;
    cur_o.second_data = d1_q;
    cur_o.sysex_count = fill_q_ext[4:0];
    nxt_o.kind        = kind_d;
    nxt_o.chan        = chan_d;
    nxt_o.first_data  = d0_d;
    nxt_o.second_data = d1_d;
    nxt_o.sysex_count = fill_d_ext[4:0];
    ev_o.multi  = accept_i && (phase_d == PH_DONE) && (kind_d == KIND_SYSEX) &&
                  (fill_d != '0);
    ev_o.single = accept_i && (phase_d == PH_DONE) && !ev_o.multi;
  end

  assign fill_o    = fill_q;
  assign rd_data_o = rd_q;

endmodule
`default_nettype wire

// File: hdl/mbp_emitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbp_emitter
// Turns events into result items: sysex sequencer, staging and output register.
// ----------------------------------------------------------------------------
module mbp_emitter #(
  parameter int SYSEX_MAX = 16,
  localparam int IDXW = (SYSEX_MAX > 1) ? $clog2(SYSEX_MAX) : 1,
  localparam int FW   = $clog2(SYSEX_MAX + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  mbp_pkg::mbp_state_t     cur_i,
  input  mbp_pkg::mbp_state_t     nxt_i,
  input  mbp_pkg::mbp_ev_t        ev_i,
  input  wire logic [FW-1:0]      fill_i,
  output logic                    rd_en_o,
  output logic [IDXW-1:0]         rd_addr_o,
  input  wire logic [6:0]         rd_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mbp_pkg::mbp_res_t       res_o
);
  import mbp_pkg::*;

  logic            seq_busy_q, seq_busy_d;
  logic [IDXW-1:0] seq_idx_q, seq_idx_d;
  logic            seq_issue, seq_last;
  logic [31:0]     seq_idx_ext;

  logic            s1_valid_q;
  mbp_res_t        s1_q;
  logic            s1_sysex_q;
  logic            s1_move, s1_free;
  mbp_res_t        s1_res;

  logic            out_valid_q;
  mbp_res_t        out_q;

  assign s1_move = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_free = !s1_valid_q || s1_move;

  assign in_stall_o = seq_busy_q || !s1_free;

  assign seq_issue   = seq_busy_q && s1_free;
  assign seq_last    = (FW'(seq_idx_q) + FW'(1)) == fill_i;
  assign seq_idx_ext = 32'(seq_idx_q);
  assign rd_en_o     = seq_issue;
  assign rd_addr_o   = seq_idx_q;

  always_comb begin
    seq_busy_d = seq_busy_q;
    seq_idx_d  = seq_idx_q;
    if (ev_i.multi) begin
      seq_busy_d = 1'b1;
      seq_idx_d  = '0;
    end else if (seq_issue) begin
      seq_idx_d = seq_idx_q + IDXW'(1);
      if (seq_last) seq_busy_d = 1'b0;
    end
  end

  // sysex items take their payload from the store read data
  always_comb begin
    s1_res = s1_q;
    if (s1_sysex_q) s1_res.payload_value = rd_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_busy_q  <= 1'b0;
      seq_idx_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seq_busy_q <= seq_busy_d;
      seq_idx_q  <= seq_idx_d;
      if (ev_i.single || seq_issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // staging register, the store read data lines up with it
  always_ff @(posedge clk_i) begin
    if (ev_i.single) begin
      s1_q.kind          <= nxt_i.kind;
      s1_q.chan          <= nxt_i.chan;
      s1_q.first_data    <= nxt_i.first_data;
      s1_q.second_data   <= nxt_i.second_data;
      s1_q.sysex_count   <= nxt_i.sysex_count;
      s1_q.payload_index <= '0;
      s1_q.payload_value <= '0;
      s1_q.last_of_event <= 1'b1;
      s1_sysex_q         <= 1'b0;
    end else if (seq_issue) begin
      s1_q.kind          <= cur_i.kind;
      s1_q.chan          <= cur_i.chan;
      s1_q.first_data    <= cur_i.first_data;
      s1_q.second_data   <= cur_i.second_data;
      s1_q.sysex_count   <= cur_i.sysex_count;
      s1_q.payload_index <= seq_idx_ext[3:0];
      s1_q.payload_value <= '0;
      s1_q.last_of_event <= seq_last;
      s1_sysex_q         <= 1'b1;
    end
    if (s1_move) begin
      out_q <= s1_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

`ifndef SYNTH
  a_seq_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_busy_q |-> in_stall_o)
    else $error("input taken while sysex bytes are being walked");

  a_seq_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_busy_q |-> (fill_i != '0))
    else $error("sysex walk with an empty store");

  a_seq_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_issue && seq_last) |=> !seq_busy_q)
    else $error("sysex walk continues past its last byte");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_sysex_q) |-> s1_q.last_of_event)
    else $error("single result event not marked last");

  a_no_event_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_i.single || ev_i.multi) |-> (in_valid_i && !seq_busy_q))
    else $error("event raised without an accepted item");
`endif

endmodule
`default_nettype wire

// File: hdl/midi_byte_stream_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_byte_stream_parser
// MIDI byte parser with running status and system exclusive collection.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle unless the input stalls. A byte that
// completes a channel message (or repeats a complete state) gives one result
// item through a staging register and an output register, and the next byte
// can be taken meanwhile unless the output stalls. A sysex event with N stored
// bytes gives N result items, one per cycle unless the output stalls, read
// from the byte store; the input stalls after the completing byte while the
// store is walked through its single registered read port. There is no clearing
// pass after reset: only entries written since the last sysex start are read.
module midi_byte_stream_parser #(
  parameter int SYSEX_MAX = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       msg_kind_o,
  output logic [3:0]       chan_o,
  output logic [6:0]       first_data_o,
  output logic [6:0]       second_data_o,
  output logic [4:0]       sysex_count_o,
  output logic [3:0]       payload_index_o,
  output logic [6:0]       payload_value_o,
  output logic             last_of_event_o
);
  import mbp_pkg::*;

  localparam int IDXW = (SYSEX_MAX > 1) ? $clog2(SYSEX_MAX) : 1;
  localparam int FW   = $clog2(SYSEX_MAX + 1);

  logic            accept;
  mbp_state_t      cur, nxt;
  mbp_ev_t         ev;
  logic [FW-1:0]   fill;
  logic            rd_en;
  logic [IDXW-1:0] rd_addr;
  logic [6:0]      rd_data;
  mbp_res_t        res;

  assign accept = in_valid_i && !in_stall_o;

  mbp_parser #(.SYSEX_MAX(SYSEX_MAX)) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cur_o     (cur),
    .nxt_o     (nxt),
    .ev_o      (ev),
    .fill_o    (fill),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  mbp_emitter #(.SYSEX_MAX(SYSEX_MAX)) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cur_i       (cur),
    .nxt_i       (nxt),
    .ev_i        (ev),
    .fill_i      (fill),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign msg_kind_o      = res.kind;
  assign chan_o          = res.chan;
  assign first_data_o    = res.first_data;
  assign second_data_o   = res.second_data;
  assign sysex_count_o   = res.sysex_count;
  assign payload_index_o = res.payload_index;
  assign payload_value_o = res.payload_value;
  assign last_of_event_o = res.last_of_event;

endmodule
`default_nettype wire
